// ===== rtl/core/bpa_pkg.sv =====
// Package with the shared widths and codes of the bitmap page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int unsigned ADDR_W = 22;
  localparam int unsigned LEN_W  = 23;
  localparam int unsigned NUM_W  = 32;

  // Width of one word of the used-bit map and of a bit index within it.
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned WORD_IDX_W = 5;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

endpackage

// ===== rtl/core/bpa_req_if.sv =====
// Request channel of the bitmap page allocator.
`timescale 1ns / 1ps

interface bpa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [bpa_pkg::ADDR_W-1:0] byte_address;
  logic [bpa_pkg::LEN_W-1:0]  byte_length;

  modport source (output valid, kind, byte_address, byte_length, input ready);
  modport sink (input valid, kind, byte_address, byte_length, output ready);
endinterface

// ===== rtl/core/bpa_rsp_if.sv =====
// Response channel of the bitmap page allocator.
`timescale 1ns / 1ps

interface bpa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bpa_pkg::ADDR_W-1:0] page_byte_address;
  logic [bpa_pkg::LEN_W-1:0]  granted_length;
  logic [bpa_pkg::NUM_W-1:0]  allocation_number;
  logic                       no_free_page;

  modport source (output valid, page_byte_address, granted_length, allocation_number,
                  no_free_page, input ready);
  modport sink (input valid, page_byte_address, granted_length, allocation_number,
                no_free_page, output ready);
endinterface

// ===== rtl/core/bitmap_page_allocator.sv =====
// First-fit page allocator over a used-bit map kept in a word-wide synchronous memory.
// An allocate scans 1 to ceil(PAGE_COUNT/32) map words; a free clears 0 to
// ceil(PAGE_COUNT/32) words. PAGE_BYTES is a power of two, so page numbers come from
// shifts. One transaction is in work at a time. After reset a clearing pass writes
// ceil(PAGE_COUNT/32) words before the first transaction is taken; the allocation
// counter resets to zero.
`timescale 1ns / 1ps

module bitmap_page_allocator #(
  parameter int unsigned PAGE_COUNT = 1024,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpa_req_if.sink    req_i,
  bpa_rsp_if.source  rsp_o
);

  localparam int unsigned NumWords = (PAGE_COUNT + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
  localparam int unsigned WordAw   = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned PW       = WordAw + bpa_pkg::WORD_IDX_W;
  localparam int unsigned BW       = PW + 1;
  localparam int unsigned PageSh   = $clog2(PAGE_BYTES);
  localparam int unsigned QW       = bpa_pkg::LEN_W + 1;
  localparam int unsigned PbW      = $clog2(PAGE_BYTES + 1);
  localparam int unsigned ProdW    = PW + PbW;
  localparam logic [WordAw-1:0] LastWord = WordAw'(NumWords - 1);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ASCAN  = 4'd2;
  localparam logic [3:0] S_AFIN   = 4'd3;
  localparam logic [3:0] S_FBND   = 4'd5;
  localparam logic [3:0] S_FSTART = 4'd6;
  localparam logic [3:0] S_FCLR   = 4'd7;
  localparam logic [3:0] S_FFIN   = 4'd8;

  logic [bpa_pkg::WORD_BITS-1:0] map_mem [NumWords];
  logic [bpa_pkg::WORD_BITS-1:0] rd_data_q;

  logic [3:0]                   state_q, state_d;
  logic [WordAw-1:0]            word_q, word_d;
  logic [WordAw-1:0]            last_w_q, last_w_d;
  logic [bpa_pkg::NUM_W-1:0]    alloc_cnt_q, alloc_cnt_d;
  logic                         out_valid_q, out_valid_d;

  logic [bpa_pkg::LEN_W-1:0]    len_q, len_d;
  logic [PW-1:0]                page_q, page_d;
  logic                         found_q, found_d;
  logic [bpa_pkg::WORD_BITS-1:0] wr_word_q, wr_word_d;
  logic [QW-1:0]                qa_q, qa_d, ql_q, ql_d;
  logic [BW-1:0]                pg_lo_q, pg_lo_d, pg_hi_q, pg_hi_d;

  logic [bpa_pkg::ADDR_W-1:0]   out_addr_q, out_addr_d;
  logic [bpa_pkg::LEN_W-1:0]    out_len_q, out_len_d;
  logic [bpa_pkg::NUM_W-1:0]    out_num_q, out_num_d;
  logic                         out_fail_q, out_fail_d;

  logic                          rd_en;
  logic [WordAw-1:0]             rd_addr;
  logic                          wr_en;
  logic [WordAw-1:0]             wr_addr;
  logic [bpa_pkg::WORD_BITS-1:0] wr_data;

  logic                          out_load;
  logic [bpa_pkg::WORD_BITS-1:0] free_bits;
  logic [bpa_pkg::WORD_BITS-1:0] clr_bits;
  logic [bpa_pkg::WORD_IDX_W-1:0] free_idx;
  logic [QW:0]                   end_full;
  logic [BW-1:0]                 hi_m1;
  logic [ProdW-1:0]              prod;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= map_mem[rd_addr];
    end
  end

  always_comb begin
    logic [BW-1:0] p;
    free_bits = '0;
    clr_bits  = '0;
    free_idx  = '0;
    for (int b = 0; b < bpa_pkg::WORD_BITS; b++) begin
      p = BW'({word_q, bpa_pkg::WORD_IDX_W'(b)});
      free_bits[b] = !rd_data_q[b] && (p < BW'(PAGE_COUNT));
      clr_bits[b]  = (p >= pg_lo_q) && (p < pg_hi_q);
    end
    for (int b = bpa_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        free_idx = bpa_pkg::WORD_IDX_W'(b);
      end
    end
  end

  assign end_full = {1'b0, qa_q} + {1'b0, ql_q};
  assign hi_m1    = pg_hi_q - BW'(1);
  assign prod     = ProdW'(page_q) * ProdW'(PAGE_BYTES);
  assign out_load = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    word_d      = word_q;
    last_w_d    = last_w_q;
    alloc_cnt_d = alloc_cnt_q;
    len_d       = len_q;
    page_d      = page_q;
    found_d     = found_q;
    wr_word_d   = wr_word_q;
    qa_d        = qa_q;
    ql_d        = ql_q;
    pg_lo_d     = pg_lo_q;
    pg_hi_d     = pg_hi_q;
    out_addr_d  = out_addr_q;
    out_len_d   = out_len_q;
    out_num_d   = out_num_q;
    out_fail_d  = out_fail_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    rd_en       = 1'b0;
    rd_addr     = word_q;
    wr_en       = 1'b0;
    wr_addr     = word_q;
    wr_data     = '0;

    unique case (state_q)
      S_INIT: begin
        wr_en = 1'b1;
        if (word_q == LastWord) begin
          state_d = S_IDLE;
        end else begin
          word_d = word_q + WordAw'(1);
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.kind == bpa_pkg::KIND_ALLOC) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            word_d  = '0;
            len_d   = req_i.byte_length;
            state_d = S_ASCAN;
          end else begin
            qa_d    = QW'(req_i.byte_address >> PageSh);
            ql_d    = QW'(({1'b0, req_i.byte_length} + QW'(PAGE_BYTES - 1)) >> PageSh);
            state_d = S_FBND;
          end
        end
      end
      S_ASCAN: begin
        if (free_bits != '0) begin
          found_d   = 1'b1;
          page_d    = {word_q, free_idx};
          wr_word_d = rd_data_q | (bpa_pkg::WORD_BITS'(1) << free_idx);
          state_d   = S_AFIN;
        end else if (word_q == LastWord) begin
          found_d = 1'b0;
          state_d = S_AFIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = word_q + WordAw'(1);
          word_d  = word_q + WordAw'(1);
        end
      end
      S_AFIN: begin
        if (out_load) begin
          wr_en       = found_q;
          wr_addr     = page_q[PW-1:bpa_pkg::WORD_IDX_W];
          wr_data     = wr_word_q;
          alloc_cnt_d = alloc_cnt_q + bpa_pkg::NUM_W'(1);
          out_valid_d = 1'b1;
          out_addr_d  = found_q ? bpa_pkg::ADDR_W'(prod) : '0;
          out_len_d   = len_q;
          out_num_d   = alloc_cnt_q + bpa_pkg::NUM_W'(1);
          out_fail_d  = !found_q;
          state_d     = S_IDLE;
        end
      end
      S_FBND: begin
        pg_lo_d = (qa_q >= QW'(PAGE_COUNT)) ? BW'(PAGE_COUNT) : qa_q[BW-1:0];
        pg_hi_d = (end_full > (QW + 1)'(PAGE_COUNT)) ? BW'(PAGE_COUNT)
                                                     : end_full[BW-1:0];
        state_d = S_FSTART;
      end
      S_FSTART: begin
        if (pg_lo_q >= pg_hi_q) begin
          state_d = S_FFIN;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = pg_lo_q[PW-1:bpa_pkg::WORD_IDX_W];
          word_d   = pg_lo_q[PW-1:bpa_pkg::WORD_IDX_W];
          last_w_d = hi_m1[PW-1:bpa_pkg::WORD_IDX_W];
          state_d  = S_FCLR;
        end
      end
      S_FCLR: begin
        wr_en   = 1'b1;
        wr_data = rd_data_q & ~clr_bits;
        if (word_q == last_w_q) begin
          state_d = S_FFIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = word_q + WordAw'(1);
          word_d  = word_q + WordAw'(1);
        end
      end
      S_FFIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_addr_d  = '0;
          out_len_d   = '0;
          out_num_d   = '0;
          out_fail_d  = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      word_q      <= '0;
      last_w_q    <= '0;
      alloc_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_q      <= word_d;
      last_w_q    <= last_w_d;
      alloc_cnt_q <= alloc_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    page_q     <= page_d;
    found_q    <= found_d;
    wr_word_q  <= wr_word_d;
    qa_q       <= qa_d;
    ql_q       <= ql_d;
    pg_lo_q    <= pg_lo_d;
    pg_hi_q    <= pg_hi_d;
    out_addr_q <= out_addr_d;
    out_len_q  <= out_len_d;
    out_num_q  <= out_num_d;
    out_fail_q <= out_fail_d;
  end

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.page_byte_address = out_addr_q;
  assign rsp_o.granted_length    = out_len_q;
  assign rsp_o.allocation_number = out_num_q;
  assign rsp_o.no_free_page      = out_fail_q;

endmodule
